// ===== hdl/b64le_pkg.sv =====
// b64le_pkg: shared types, constants and the character table of the
// line wrapped base64 encoder. No dependencies.
package b64le_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CharW   = 7;
  localparam int unsigned SextW   = 6;
  localparam int unsigned LimitW  = 8;
  localparam int unsigned JobLen  = 6;
  localparam int unsigned IdxW    = 3;

  localparam logic [LimitW-1:0] LineLimitReset = 8'd76;

  localparam logic [CharW-1:0] ChCr  = 7'd13;
  localparam logic [CharW-1:0] ChLf  = 7'd10;
  localparam logic [CharW-1:0] ChPad = 7'd61;

  // one encoded group: characters in emission order, 4 or 6 of them
  typedef struct packed {
    logic [JobLen-1:0][CharW-1:0] chars;
    logic                         crlf;
  } job_t;

  // standard alphabet A-Z a-z 0-9 + /
  function automatic logic [CharW-1:0] enc_char(input logic [SextW-1:0] v);
    logic [CharW-1:0] c;
    begin
      if (v < 6'd26) begin
        c = 7'(v) + 7'd65;
      end else if (v < 6'd52) begin
        c = 7'(v) + 7'd71;
      end else if (v < 6'd62) begin
        c = 7'(v) - 7'd4;
      end else if (v == 6'd62) begin
        c = 7'd43;
      end else begin
        c = 7'd47;
      end
      return c;
    end
  endfunction

endpackage

// ===== hdl/b64le_ifs.sv =====
// b64le_ifs: valid/ready channel interfaces for bytes in and characters out.
// Depends on b64le_pkg.
interface b64le_byte_if;
  import b64le_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             end_of_data;

  modport source (output valid, output data_byte, output end_of_data, input ready);
  modport sink   (input valid, input data_byte, input end_of_data, output ready);
endinterface

interface b64le_char_if;
  import b64le_pkg::*;
  logic             valid;
  logic             ready;
  logic [CharW-1:0] out_char;
  logic             last_char;

  modport source (output valid, output out_char, output last_char, input ready);
  modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

// ===== hdl/b64le_front.sv =====
// b64le_front: accepts bytes, gathers groups, tracks the line count and
// builds one character job per finished group. Depends on b64le_pkg.
module b64le_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [b64le_pkg::LimitW-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [b64le_pkg::ByteW-1:0]   in_byte_i,
  input  logic                          in_last_i,
  output logic                          push_o,
  output b64le_pkg::job_t               push_job_o,
  input  logic                          q_full_i
);
  import b64le_pkg::*;

  logic [LimitW-1:0]  limit_q;
  logic [2*ByteW-1:0] held_q, held_d;
  logic [1:0]         cnt_q, cnt_d;
  logic [LimitW-1:0]  line_q, line_d;

  logic               acc;
  logic               emit;
  logic [3:0]         nchar;
  logic [LimitW:0]    sum;
  logic               crlf;
  logic [23:0]        g;
  job_t               job;

  assign in_ready_o = !q_full_i;
  assign acc        = in_valid_i && in_ready_o;
  assign emit       = (cnt_q == 2'd2) || in_last_i;
  assign g          = {held_q, in_byte_i};

  always_comb begin
    if (cnt_q == 2'd2) begin
      nchar = 4'd4;
    end else if (cnt_q == 2'd1) begin
      nchar = 4'd3;
    end else begin
      nchar = 4'd2;
    end
  end

  assign sum  = {1'b0, line_q} + (LimitW+1)'(nchar);
  assign crlf = sum >= {1'b0, limit_q};

  always_comb begin
    job.crlf = crlf;
    for (int i = 0; i < JobLen; i++) begin
      job.chars[i] = ChPad;
    end
    if (cnt_q == 2'd2) begin
      job.chars[0] = enc_char(g[23:18]);
      job.chars[1] = enc_char(g[17:12]);
      job.chars[2] = enc_char(g[11:6]);
      job.chars[3] = enc_char(g[5:0]);
      job.chars[4] = ChCr;
      job.chars[5] = ChLf;
    end else if (cnt_q == 2'd1) begin
      job.chars[0] = enc_char(g[15:10]);
      job.chars[1] = enc_char(g[9:4]);
      job.chars[2] = enc_char({g[3:0], 2'b00});
      job.chars[3] = crlf ? ChCr : ChPad;
      job.chars[4] = ChLf;
      job.chars[5] = ChPad;
    end else begin
      job.chars[0] = enc_char(g[7:2]);
      job.chars[1] = enc_char({g[1:0], 4'b0000});
      job.chars[2] = crlf ? ChCr : ChPad;
      job.chars[3] = crlf ? ChLf : ChPad;
    end
  end

  assign push_o     = acc && emit;
  assign push_job_o = job;

  always_comb begin
    held_d = held_q;
    cnt_d  = cnt_q;
    line_d = line_q;
    if (acc) begin
      if (emit) begin
        line_d = crlf ? '0 : sum[LimitW-1:0];
        held_d = '0;
        cnt_d  = '0;
      end else begin
        held_d = {held_q[ByteW-1:0], in_byte_i};
        cnt_d  = cnt_q + 2'd1;
      end
      if (in_last_i) begin
        held_d = '0;
        cnt_d  = '0;
        line_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LineLimitReset;
      held_q  <= '0;
      cnt_q   <= '0;
      line_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      held_q <= held_d;
      cnt_q  <= cnt_d;
      line_q <= line_d;
    end
  end

endmodule

// ===== hdl/b64le_queue.sv =====
// b64le_queue: two entry job queue between front and back.
// Depends on b64le_pkg.
module b64le_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  b64le_pkg::job_t push_job_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output b64le_pkg::job_t head_o
);
  import b64le_pkg::*;

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// ===== hdl/b64le_back.sv =====
// b64le_back: walks the head job into the output register one character per
// cycle while the output is not stalled. Depends on b64le_pkg.
module b64le_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  input  b64le_pkg::job_t              q_head_i,
  output logic                         q_pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [b64le_pkg::CharW-1:0]  out_char_o,
  output logic                         out_last_o
);
  import b64le_pkg::*;

  logic [IdxW-1:0]  idx_q, idx_d;
  logic             ovalid_q, ovalid_d;
  logic [CharW-1:0] char_q;
  logic             last_q;

  logic             adv;
  logic             take;
  logic             is_last;

  assign adv     = !ovalid_q || out_ready_i;
  assign take    = adv && q_valid_i;
  assign is_last = q_head_i.crlf ? (idx_q == IdxW'(JobLen - 1)) : (idx_q == IdxW'(3));
  assign q_pop_o = take && is_last;

  always_comb begin
    idx_d    = idx_q;
    ovalid_d = ovalid_q;
    if (adv) begin
      ovalid_d = q_valid_i;
    end
    if (take) begin
      idx_d = is_last ? '0 : idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      char_q <= q_head_i.chars[idx_q];
      last_q <= is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_char_o  = char_q;
  assign out_last_o  = last_q;

endmodule

// ===== hdl/base64_line_wrapped_encoder_top.sv =====
// Base64 encoder with CR LF line wrapping, one byte in, one character out.
// in_i carries data_byte and end_of_data; a transaction is valid && ready.
// out_o carries out_char and last_char; last_char marks the final character
// caused by one input byte. A byte that does not close a group or the buffer
// produces no characters. cfg_we_i/cfg_wdata_i write line_limit (reset 76);
// write it only while the block is idle.
// The byte that finishes a group pushes its job into the queue; the back
// then loads the first character of the queue head into the output register.
// The output runs at one character per cycle while the receiver takes them
// and a job is queued, set by the single character register at the back;
// three bytes give four characters, or six when a line break follows. A
// two entry job queue lets bytes keep coming in while a group is still being
// sent. When the receiver stalls the output register holds its character
// and the queue fills; in_i.ready drops once the queue holds two jobs, the
// one being sent included.
// Reset clears the held bytes, the line count, the queue and the output
// valid, and restores line_limit to 76.
// Depends on b64le_pkg, b64le_ifs, b64le_front, b64le_queue, b64le_back.
module base64_line_wrapped_encoder_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [b64le_pkg::LimitW-1:0] cfg_wdata_i,
  b64le_byte_if.sink                   in_i,
  b64le_char_if.source                 out_o
);
  import b64le_pkg::*;

  logic push;
  job_t push_job;
  logic q_full;
  logic q_pop;
  logic q_valid;
  job_t q_head;

  b64le_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_byte_i   (in_i.data_byte),
    .in_last_i   (in_i.end_of_data),
    .push_o      (push),
    .push_job_o  (push_job),
    .q_full_i    (q_full)
  );

  b64le_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  b64le_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_char_o  (out_o.out_char),
    .out_last_o  (out_o.last_char)
  );

endmodule
